@@ design/tce_pkg.sv @@
package tce_pkg;

    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int XLEN      = 32;
    localparam logic [XLEN-1:0] SP_RESET = XLEN'(4 * MEM_WORDS);

    typedef enum logic [4:0] {
        OP_NOP   = 5'd0,  OP_HALT  = 5'd1,  OP_ADD   = 5'd2,  OP_SUB   = 5'd3,
        OP_MUL   = 5'd4,  OP_DIV   = 5'd5,  OP_AND   = 5'd6,  OP_OR    = 5'd7,
        OP_XOR   = 5'd8,  OP_NOT   = 5'd9,  OP_SHL   = 5'd10, OP_SHR   = 5'd11,
        OP_MOV   = 5'd12, OP_LOAD  = 5'd13, OP_STMEM = 5'd14, OP_LDIMM = 5'd15,
        OP_PUSH  = 5'd16, OP_POP   = 5'd17, OP_JMP   = 5'd18, OP_JZ    = 5'd19,
        OP_JNZ   = 5'd20, OP_JG    = 5'd21, OP_JL    = 5'd22, OP_CALL  = 5'd23,
        OP_RET   = 5'd24, OP_IN    = 5'd25, OP_OUT   = 5'd26
    } opcode_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_HALT = 2'd1,
        ST_DIV0 = 2'd2,
        ST_ILL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [4:0]  req_type;
        logic [3:0]  dest_reg;
        logic [3:0]  src_reg;
        logic signed [15:0] immediate;
        logic [31:0] in_value;
    } req_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  status;
        logic        out_valid;
        logic [31:0] out_value;
        logic [3:0]  flag_bits;
    } rsp_t;

endpackage

@@ design/tce_req_if.sv @@
interface tce_req_if;
    logic               valid;
    logic               ready;
    tce_pkg::req_t      payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/tce_rsp_if.sv @@
interface tce_rsp_if;
    logic               valid;
    logic               ready;
    tce_pkg::rsp_t      payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/two_operand_cpu_execute.sv @@
// order: most instructions go from the execute state straight to the output state;
// load/pop/ret pass a memory-read state first, mul and div 32 shared shift-add/subtract
// steps and a finish state; a halted core or a div by zero goes straight to output
// flow: one word in flight; the next word is taken in the cycle after the result is taken
// reset: registers, pc, flags and halted mark clear, stack pointer = 4 * memory words
// data memory is not cleared; reads of unwritten words are undefined
module two_operand_cpu_execute (
    input  logic       clk,
    input  logic       rst_n,
    tce_req_if.sink    req,
    tce_rsp_if.source  rsp
);

    localparam int XL = tce_pkg::XLEN;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_ITER = 6'b000100,
        S_MEMR = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [XL-1:0] rf_reg [tce_pkg::REG_COUNT];
    logic [XL-1:0] mem [tce_pkg::MEM_WORDS];
    logic [XL-1:0] rdata_reg;

    logic [XL-1:0]    pc_reg, pc_next, sp_reg, sp_next;
    logic [3:0]       flag_reg, flag_next;
    logic             halted_reg, halted_next;
    tce_pkg::req_t    ir_reg, ir_next;
    tce_pkg::status_t status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    logic [XL-1:0]    out_value_reg, out_value_next;

    // shared iterative unit operands and accumulators
    logic [XL-1:0] a_reg, a_next, b_reg, b_next;
    logic [XL-1:0] acc_reg, acc_next, quo_reg, quo_next;
    logic [5:0]    cnt_reg, cnt_next;

    // register file write port
    logic          rf_we;
    logic [XL-1:0] rf_wdata;

    logic [tce_pkg::REG_AW-1:0] d_idx, s_idx;
    logic [XL-1:0] imm32, pc4;
    assign d_idx = ir_reg.dest_reg[tce_pkg::REG_AW-1:0];
    assign s_idx = ir_reg.src_reg[tce_pkg::REG_AW-1:0];
    assign imm32 = {{(XL-16){ir_reg.immediate[15]}}, ir_reg.immediate};
    assign pc4   = pc_reg + XL'(4);

    // combinational alu results
    logic [XL-1:0] sum, diff, shl_r, shr_r;
    assign sum   = a_reg + b_reg;
    assign diff  = a_reg - b_reg;
    assign shl_r = (b_reg >= XL'(32)) ? '0 : a_reg << b_reg[4:0];
    assign shr_r = (b_reg >= XL'(32)) ? '0 : a_reg >> b_reg[4:0];

    // memory access address and write control
    logic [XL-1:0] maddr, mwdata;
    logic          mwe, mre;
    always_comb
    begin
        maddr  = '0;
        mwdata = a_reg;
        mwe    = 1'b0;
        mre    = 1'b0;
        if (state_reg == S_EXEC && !halted_reg)
        begin
            case (ir_reg.req_type)
                tce_pkg::OP_LOAD:  begin maddr = b_reg + imm32; mre = 1'b1; end
                tce_pkg::OP_STMEM: begin maddr = a_reg + imm32; mwdata = b_reg; mwe = 1'b1; end
                tce_pkg::OP_PUSH:  begin maddr = sp_reg - XL'(4); mwe = 1'b1; end
                tce_pkg::OP_CALL:  begin maddr = sp_reg - XL'(4); mwdata = pc4; mwe = 1'b1; end
                tce_pkg::OP_POP,
                tce_pkg::OP_RET:   begin maddr = sp_reg; mre = 1'b1; end
                default: ;
            endcase
        end
    end

    // data memory with registered read
    always_ff @(posedge clk)
    begin
        if (mwe)
            mem[maddr[tce_pkg::MEM_AW+1:2]] <= mwdata;
        if (mre)
            rdata_reg <= mem[maddr[tce_pkg::MEM_AW+1:2]];
    end

    // divide step of the shared shift-add / restoring-divide unit
    logic [XL:0]   trial;
    logic [XL-1:0] rem_sh;
    assign rem_sh = {acc_reg[XL-2:0], quo_reg[XL-1]};
    assign trial  = {acc_reg[XL-1], rem_sh} - {1'b0, b_reg};

    // z and n from a result, c and o kept
    function automatic logic [3:0] zn(input logic [3:0] f, input logic [XL-1:0] r);
        zn = {r[XL-1], f[2], f[1], r == '0};
    endfunction

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);

    // result word: pc and flags are settled once the output state is reached
    always_comb
    begin
        rsp.payload.next_pc   = pc_reg;
        rsp.payload.status    = status_reg;
        rsp.payload.out_valid = out_valid_reg;
        rsp.payload.out_value = out_value_reg;
        rsp.payload.flag_bits = flag_reg;
    end

    // sequencer and next machine state
    always_comb
    begin
        state_next     = state_reg;
        ir_next        = ir_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        pc_next        = pc_reg;
        sp_next        = sp_reg;
        flag_next      = flag_reg;
        halted_next    = halted_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        rf_we          = 1'b0;
        rf_wdata       = '0;
        case (state_reg)
            S_IDLE:
                if (req.valid)
                begin
                    state_next = S_EXEC;
                    ir_next    = req.payload;
                    a_next     = rf_reg[req.payload.dest_reg[tce_pkg::REG_AW-1:0]];
                    b_next     = rf_reg[req.payload.src_reg[tce_pkg::REG_AW-1:0]];
                end
            S_EXEC:
            begin
                state_next     = S_OUT;
                status_next    = tce_pkg::ST_RUN;
                out_valid_next = 1'b0;
                out_value_next = '0;
                acc_next       = '0;
                quo_next       = a_reg;
                cnt_next       = '0;
                if (halted_reg)
                    status_next = tce_pkg::ST_HALT;
                else
                begin
                    pc_next = pc4;
                    case (ir_reg.req_type)
                        tce_pkg::OP_NOP, tce_pkg::OP_STMEM: ;
                        tce_pkg::OP_HALT:
                        begin
                            halted_next = 1'b1;
                            status_next = tce_pkg::ST_HALT;
                        end
                        tce_pkg::OP_ADD:
                        begin
                            rf_we     = 1'b1;
                            rf_wdata  = sum;
                            flag_next = {sum[XL-1],
                                         ~(a_reg[XL-1] ^ b_reg[XL-1]) & (a_reg[XL-1] ^ sum[XL-1]),
                                         sum < a_reg,
                                         sum == '0};
                        end
                        tce_pkg::OP_SUB:
                        begin
                            rf_we     = 1'b1;
                            rf_wdata  = diff;
                            flag_next = {diff[XL-1],
                                         (a_reg[XL-1] ^ b_reg[XL-1]) & (a_reg[XL-1] ^ diff[XL-1]),
                                         a_reg < b_reg,
                                         diff == '0};
                        end
                        tce_pkg::OP_MUL: state_next = S_ITER;
                        tce_pkg::OP_DIV:
                            if (b_reg == '0)
                            begin
                                halted_next = 1'b1;
                                status_next = tce_pkg::ST_DIV0;
                            end
                            else
                                state_next = S_ITER;
                        tce_pkg::OP_AND:
                        begin
                            rf_we     = 1'b1;
                            rf_wdata  = a_reg & b_reg;
                            flag_next = zn(flag_reg, a_reg & b_reg);
                        end
                        tce_pkg::OP_OR:
                        begin
                            rf_we     = 1'b1;
                            rf_wdata  = a_reg | b_reg;
                            flag_next = zn(flag_reg, a_reg | b_reg);
                        end
                        tce_pkg::OP_XOR:
                        begin
                            rf_we     = 1'b1;
                            rf_wdata  = a_reg ^ b_reg;
                            flag_next = zn(flag_reg, a_reg ^ b_reg);
                        end
                        tce_pkg::OP_NOT:
                        begin
                            rf_we     = 1'b1;
                            rf_wdata  = ~a_reg;
                            flag_next = zn(flag_reg, ~a_reg);
                        end
                        tce_pkg::OP_SHL:
                        begin
                            rf_we     = 1'b1;
                            rf_wdata  = shl_r;
                            flag_next = zn(flag_reg, shl_r);
                        end
                        tce_pkg::OP_SHR:
                        begin
                            rf_we     = 1'b1;
                            rf_wdata  = shr_r;
                            flag_next = zn(flag_reg, shr_r);
                        end
                        tce_pkg::OP_MOV:   begin rf_we = 1'b1; rf_wdata = b_reg; end
                        tce_pkg::OP_LOAD,
                        tce_pkg::OP_POP,
                        tce_pkg::OP_RET:   state_next = S_MEMR;
                        tce_pkg::OP_LDIMM: begin rf_we = 1'b1; rf_wdata = imm32; end
                        tce_pkg::OP_PUSH:  sp_next = sp_reg - XL'(4);
                        tce_pkg::OP_JMP:   pc_next = imm32;
                        tce_pkg::OP_JZ:    if (flag_reg[0]) pc_next = imm32;
                        tce_pkg::OP_JNZ:   if (!flag_reg[0]) pc_next = imm32;
                        tce_pkg::OP_JG:
                            if (!flag_reg[0] && flag_reg[3] == flag_reg[2]) pc_next = imm32;
                        tce_pkg::OP_JL:
                            if (flag_reg[3] != flag_reg[2]) pc_next = imm32;
                        tce_pkg::OP_CALL:
                        begin
                            sp_next = sp_reg - XL'(4);
                            pc_next = imm32;
                        end
                        tce_pkg::OP_IN:    begin rf_we = 1'b1; rf_wdata = ir_reg.in_value; end
                        tce_pkg::OP_OUT:
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = a_reg;
                        end
                        default:
                        begin
                            halted_next = 1'b1;
                            status_next = tce_pkg::ST_ILL;
                        end
                    endcase
                end
            end
            S_ITER:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                    state_next = S_FIN;
                if (ir_reg.req_type == tce_pkg::OP_MUL)
                begin
                    // shift-add, multiplier bits from the top
                    acc_next = (acc_reg << 1) + (quo_reg[XL-1] ? b_reg : '0);
                    quo_next = quo_reg << 1;
                end
                else
                begin
                    // restoring divide, one quotient bit a step
                    if (!trial[XL])
                        acc_next = trial[XL-1:0];
                    else
                        acc_next = rem_sh;
                    quo_next = {quo_reg[XL-2:0], ~trial[XL]};
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
                rf_we      = 1'b1;
                if (ir_reg.req_type == tce_pkg::OP_MUL)
                    rf_wdata = acc_reg;
                else
                    rf_wdata = quo_reg;
                flag_next = zn(flag_reg, rf_wdata);
            end
            S_MEMR:
            begin
                state_next = S_OUT;
                case (ir_reg.req_type)
                    tce_pkg::OP_LOAD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = rdata_reg;
                    end
                    tce_pkg::OP_POP:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = rdata_reg;
                        sp_next  = sp_reg + XL'(4);
                    end
                    default:
                    begin
                        pc_next = rdata_reg;
                        sp_next = sp_reg + XL'(4);
                    end
                endcase
            end
            S_OUT: if (rsp.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ir_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            pc_reg        <= '0;
            sp_reg        <= tce_pkg::SP_RESET;
            flag_reg      <= '0;
            halted_reg    <= 1'b0;
            status_reg    <= tce_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            acc_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            for (int i = 0; i < tce_pkg::REG_COUNT; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ir_reg        <= ir_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            flag_reg      <= flag_next;
            halted_reg    <= halted_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            acc_reg       <= acc_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
            if (rf_we)
                rf_reg[d_idx] <= rf_wdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("ready and result valid together");
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(halted_reg) |-> halted_reg)
        else $error("halted mark cleared");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER) |-> cnt_reg < 6'd32)
        else $error("iteration count overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid)
        else $error("result dropped");

endmodule
